/* rtl/pmbs_pkg.sv */
`timescale 1ns / 1ps

package pmbs_pkg;

    // channel count and history memory addressing
    localparam int CHANNELS = 16;
    localparam int ADDR_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // field widths
    localparam int CH_W      = 4;
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 25;
    localparam int HIST_W    = 24;
    localparam int CFG_IDX_W = 3;

    // fixed point positions
    localparam int COEF_FRAC_BITS = 22;
    localparam int SAMPLE_FRAC    = 15;
    localparam int HIST_FRAC      = 20;
    localparam int X_SHIFT        = HIST_FRAC - SAMPLE_FRAC;

    // product and accumulator widths
    localparam int SUM_W = SAMPLE_W + 1;
    localparam int PO_W  = COEF_W + SUM_W;
    localparam int PM_W  = COEF_W + SAMPLE_W;
    localparam int PF_W  = COEF_W + HIST_W;
    localparam int ACC_W = PF_W + 2;
    localparam int Q_W   = HIST_W + 1;

    localparam logic signed [ACC_W-1:0] ROUND_HALF =
        ACC_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] HIST_MAX_A =
        ACC_W'((64'sd1 <<< (HIST_W - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] HIST_MIN_A =
        ACC_W'(-(64'sd1 <<< (HIST_W - 1)));
    localparam logic signed [HIST_W-1:0] HIST_MAX =
        HIST_W'((64'sd1 <<< (HIST_W - 1)) - 64'sd1);
    localparam logic signed [HIST_W-1:0] HIST_MIN =
        HIST_W'(-(64'sd1 <<< (HIST_W - 1)));

    localparam logic signed [Q_W-1:0] Q15_HALF =
        Q_W'(64'sd1 <<< (X_SHIFT - 1));
    localparam logic signed [Q_W-1:0] Q15_MAX_W =
        Q_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
    localparam logic signed [Q_W-1:0] Q15_MIN_W =
        Q_W'(-(64'sd1 <<< (SAMPLE_W - 1)));
    localparam logic signed [SAMPLE_W-1:0] Q15_MAX =
        SAMPLE_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
    localparam logic signed [SAMPLE_W-1:0] Q15_MIN =
        SAMPLE_W'(-(64'sd1 <<< (SAMPLE_W - 1)));

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FB_ONE      = 3'd0,
        REG_FB_TWO      = 3'd1,
        REG_LOW_OUTER   = 3'd2,
        REG_LOW_MIDDLE  = 3'd3,
        REG_HIGH_OUTER  = 3'd4,
        REG_HIGH_MIDDLE = 3'd5
    } cfg_reg_t;

    // one channel's history entry
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x1;
        logic signed [SAMPLE_W-1:0] x2;
        logic signed [HIST_W-1:0]   lo1;
        logic signed [HIST_W-1:0]   lo2;
        logic signed [HIST_W-1:0]   hi1;
        logic signed [HIST_W-1:0]   hi2;
    } hist_t;

    // load enables of the arithmetic stages
    typedef struct packed {
        logic b;
        logic c;
        logic d;
    } stage_en_t;

endpackage

/* rtl/phase_matched_band_split_filter.sv */
`timescale 1ns / 1ps

// Phase-matched band split: each item carries a channel and a q1.15 sample and returns the
// channel with a low band and a high band, both q1.15 rounded and saturated, plus a clip
// flag. Per-channel history (last two inputs, last two q3.20 outputs of each band) sits in
// one 16 x 128-bit synchronous memory that reset clears through per-entry valid bits, so the
// block is ready right after reset. An item is read from memory, multiplied, summed and
// rounded over a five stage pipeline (read, multiply, sum, write back, output register).
// One item is taken per cycle as long as the output side does not hold the pipeline and
// its channel differs from the items in the read, multiply and sum stages; an item for
// the same channel waits for the earlier one's write back. Coefficients must be written
// on the cfg port only while no item is in flight; the block itself does not enforce it.

module phase_matched_band_split_filter
    import pmbs_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [COEF_W-1:0]           cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [CH_W-1:0]             channel,
    input  logic signed [SAMPLE_W-1:0]  sample_in,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [CH_W-1:0]             channel_out,
    output logic signed [SAMPLE_W-1:0]  low_band,
    output logic signed [SAMPLE_W-1:0]  high_band,
    output logic                        clipped
);

    // coefficient registers
    logic signed [COEF_W-1:0] fb_one_reg;
    logic signed [COEF_W-1:0] fb_two_reg;
    logic signed [COEF_W-1:0] low_outer_reg;
    logic signed [COEF_W-1:0] low_middle_reg;
    logic signed [COEF_W-1:0] high_outer_reg;
    logic signed [COEF_W-1:0] high_middle_reg;

    // pipeline control
    logic va_reg, vb_reg, vc_reg, vd_reg;
    logic out_valid_reg;
    logic en_a, en_out;
    stage_en_t en;
    logic hazard;
    logic accept;
    logic in_range;

    // item data carried alongside the arithmetic
    logic [CH_W-1:0]            ch_a_reg, ch_b_reg, ch_c_reg, ch_d_reg;
    logic                       inr_a_reg, inr_b_reg, inr_c_reg, inr_d_reg;
    logic signed [SAMPLE_W-1:0] x_a_reg, x_b_reg, x_c_reg;
    logic signed [SAMPLE_W-1:0] x1_b_reg, x1_c_reg;

    // output register payload
    logic [CH_W-1:0]            channel_out_reg;
    logic signed [SAMPLE_W-1:0] low_band_reg;
    logic signed [SAMPLE_W-1:0] high_band_reg;
    logic                       clipped_reg;

    // memory and band units
    hist_t                      rd_hist;
    hist_t                      wr_hist;
    logic                       wr_en;
    logic signed [HIST_W-1:0]   lo_new, lo_prev, hi_new, hi_prev;
    logic signed [SAMPLE_W-1:0] lo_q15, hi_q15;
    logic                       lo_sat, hi_sat;

    // coefficient writes, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_one_reg      <= '0;
            fb_two_reg      <= '0;
            low_outer_reg   <= '0;
            low_middle_reg  <= '0;
            high_outer_reg  <= '0;
            high_middle_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_FB_ONE:      fb_one_reg      <= cfg_data;
                REG_FB_TWO:      fb_two_reg      <= cfg_data;
                REG_LOW_OUTER:   low_outer_reg   <= cfg_data;
                REG_LOW_MIDDLE:  low_middle_reg  <= cfg_data;
                REG_HIGH_OUTER:  high_outer_reg  <= cfg_data;
                REG_HIGH_MIDDLE: high_middle_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // a stage loads when it is empty or its content moves on
    assign en_out = !out_valid_reg || out_ready;
    assign en.d   = !vd_reg || en_out;
    assign en.c   = !vc_reg || en.d;
    assign en.b   = !vb_reg || en.c;
    assign en_a   = !va_reg || en.b;

    // same-channel interlock until the earlier item has written back
    assign hazard = (va_reg && (ch_a_reg == channel))
                 || (vb_reg && (ch_b_reg == channel))
                 || (vc_reg && (ch_c_reg == channel));

    assign in_ready = en_a && !hazard;
    assign accept   = in_valid && in_ready;
    assign in_range = int'(channel) < CHANNELS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            vd_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                va_reg <= accept;
            end
            if (en.b)
            begin
                vb_reg <= va_reg;
            end
            if (en.c)
            begin
                vc_reg <= vb_reg;
            end
            if (en.d)
            begin
                vd_reg <= vc_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= vd_reg;
            end
        end
    end

    // item data pipeline
    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            ch_a_reg  <= channel;
            inr_a_reg <= in_range;
            x_a_reg   <= sample_in;
        end
        if (en.b)
        begin
            ch_b_reg  <= ch_a_reg;
            inr_b_reg <= inr_a_reg;
            x_b_reg   <= x_a_reg;
            x1_b_reg  <= rd_hist.x1;
        end
        if (en.c)
        begin
            ch_c_reg  <= ch_b_reg;
            inr_c_reg <= inr_b_reg;
            x_c_reg   <= x_b_reg;
            x1_c_reg  <= x1_b_reg;
        end
        if (en.d)
        begin
            ch_d_reg  <= ch_c_reg;
            inr_d_reg <= inr_c_reg;
        end
        if (en_out && vd_reg)
        begin
            channel_out_reg <= ch_d_reg;
            low_band_reg    <= inr_d_reg ? lo_q15 : '0;
            high_band_reg   <= inr_d_reg ? hi_q15 : '0;
            clipped_reg     <= inr_d_reg && (lo_sat || hi_sat);
        end
    end

    // history memory, read at accept, written as the sum leaves stage c
    pmbs_hist_ram u_hist_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (en_a),
        .rd_addr (ADDR_W'(channel)),
        .rd_data (rd_hist),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(ch_c_reg)),
        .wr_data (wr_hist)
    );

    assign wr_en = en.d && vc_reg && inr_c_reg;

    always_comb
    begin
        wr_hist.x1  = x_c_reg;
        wr_hist.x2  = x1_c_reg;
        wr_hist.lo1 = lo_new;
        wr_hist.lo2 = lo_prev;
        wr_hist.hi1 = hi_new;
        wr_hist.hi2 = hi_prev;
    end

    // low band section
    pmbs_band u_low (
        .clk       (clk),
        .en        (en),
        .ff_outer  (low_outer_reg),
        .ff_middle (low_middle_reg),
        .fb_one    (fb_one_reg),
        .fb_two    (fb_two_reg),
        .x0        (x_a_reg),
        .x1        (rd_hist.x1),
        .x2        (rd_hist.x2),
        .y1        (rd_hist.lo1),
        .y2        (rd_hist.lo2),
        .y_new     (lo_new),
        .y_prev    (lo_prev),
        .q15       (lo_q15),
        .sat       (lo_sat)
    );

    // high band section, same denominator
    pmbs_band u_high (
        .clk       (clk),
        .en        (en),
        .ff_outer  (high_outer_reg),
        .ff_middle (high_middle_reg),
        .fb_one    (fb_one_reg),
        .fb_two    (fb_two_reg),
        .x0        (x_a_reg),
        .x1        (rd_hist.x1),
        .x2        (rd_hist.x2),
        .y1        (rd_hist.hi1),
        .y2        (rd_hist.hi2),
        .y_new     (hi_new),
        .y_prev    (hi_prev),
        .q15       (hi_q15),
        .sat       (hi_sat)
    );

    assign out_valid   = out_valid_reg;
    assign channel_out = channel_out_reg;
    assign low_band    = low_band_reg;
    assign high_band   = high_band_reg;
    assign clipped     = clipped_reg;

endmodule

/* rtl/pmbs_hist_ram.sv */
`timescale 1ns / 1ps

module pmbs_hist_ram
    import pmbs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output hist_t             rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  hist_t             wr_data
);

    hist_t mem [CHANNELS];

    logic [CHANNELS-1:0] vld_reg;
    hist_t               rd_data_reg;
    logic                rd_vld_reg;

    // entry valid bits, a never written entry reads as zero history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

/* rtl/pmbs_band.sv */
`timescale 1ns / 1ps

module pmbs_band
    import pmbs_pkg::*;
(
    input  logic                       clk,
    input  stage_en_t                  en,
    input  logic signed [COEF_W-1:0]   ff_outer,
    input  logic signed [COEF_W-1:0]   ff_middle,
    input  logic signed [COEF_W-1:0]   fb_one,
    input  logic signed [COEF_W-1:0]   fb_two,
    input  logic signed [SAMPLE_W-1:0] x0,
    input  logic signed [SAMPLE_W-1:0] x1,
    input  logic signed [SAMPLE_W-1:0] x2,
    input  logic signed [HIST_W-1:0]   y1,
    input  logic signed [HIST_W-1:0]   y2,
    output logic signed [HIST_W-1:0]   y_new,
    output logic signed [HIST_W-1:0]   y_prev,
    output logic signed [SAMPLE_W-1:0] q15,
    output logic                       sat
);

    logic signed [SUM_W-1:0]  x_sum;
    logic signed [PO_W-1:0]   p_outer_reg;
    logic signed [PM_W-1:0]   p_mid_reg;
    logic signed [PF_W-1:0]   p_fb1_reg;
    logic signed [PF_W-1:0]   p_fb2_reg;
    logic signed [HIST_W-1:0] y1_b_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [HIST_W-1:0] y1_c_reg;
    logic signed [ACC_W-1:0]  acc_rnd;
    logic signed [ACC_W-1:0]  acc_shr;
    logic                     hist_sat;
    logic signed [HIST_W-1:0] y_d_reg;
    logic                     sat_d_reg;
    logic signed [Q_W-1:0]    q_rnd;
    logic signed [Q_W-1:0]    q_shr;
    logic                     q_sat;

    // outer tap applies to current and oldest input alike
    assign x_sum = SUM_W'(x0) + SUM_W'(x2);

    // stage b: products
    always_ff @(posedge clk)
    begin
        if (en.b)
        begin
            p_outer_reg <= PO_W'(ff_outer) * PO_W'(x_sum);
            p_mid_reg   <= PM_W'(ff_middle) * PM_W'(x1);
            p_fb1_reg   <= PF_W'(fb_one) * PF_W'(y1);
            p_fb2_reg   <= PF_W'(fb_two) * PF_W'(y2);
            y1_b_reg    <= y1;
        end
    end

    // stage c: exact sum, inputs lifted to the history fraction
    assign acc_next = (ACC_W'(p_outer_reg) <<< X_SHIFT) + (ACC_W'(p_mid_reg) <<< X_SHIFT)
                    - ACC_W'(p_fb1_reg) - ACC_W'(p_fb2_reg);

    always_ff @(posedge clk)
    begin
        if (en.c)
        begin
            acc_reg  <= acc_next;
            y1_c_reg <= y1_b_reg;
        end
    end

    // round half up to q3.20 and saturate
    assign acc_rnd = acc_reg + ROUND_HALF;
    assign acc_shr = acc_rnd >>> COEF_FRAC_BITS;

    always_comb
    begin
        hist_sat = 1'b0;
        y_new    = HIST_W'(acc_shr);
        if (acc_shr > HIST_MAX_A)
        begin
            hist_sat = 1'b1;
            y_new    = HIST_MAX;
        end
        else if (acc_shr < HIST_MIN_A)
        begin
            hist_sat = 1'b1;
            y_new    = HIST_MIN;
        end
    end

    assign y_prev = y1_c_reg;

    // stage d: stored value, then q1.15 view of it
    always_ff @(posedge clk)
    begin
        if (en.d)
        begin
            y_d_reg   <= y_new;
            sat_d_reg <= hist_sat;
        end
    end

    assign q_rnd = Q_W'(y_d_reg) + Q15_HALF;
    assign q_shr = q_rnd >>> X_SHIFT;

    always_comb
    begin
        q_sat = 1'b0;
        q15   = SAMPLE_W'(q_shr);
        if (q_shr > Q15_MAX_W)
        begin
            q_sat = 1'b1;
            q15   = Q15_MAX;
        end
        else if (q_shr < Q15_MIN_W)
        begin
            q_sat = 1'b1;
            q15   = Q15_MIN;
        end
    end

    assign sat = sat_d_reg | q_sat;

endmodule

/* bench/tb_phase_matched_band_split_filter.sv */
`timescale 1ns / 1ps

module tb_phase_matched_band_split_filter;
    import pmbs_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 5;
    localparam int CYCLE_LIMIT   = 300000;
    // five stage pipeline plus a little margin
    localparam int SETTLE_CYCLES = 12;
    // long enough to back the pipeline up into the input
    localparam int HOLD_CYCLES   = 80;

    // indexes past the register list, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HIGH = 3'd7;

    // q2.22 coefficient values
    localparam logic [COEF_W-1:0] COEF_ZERO     = '0;
    localparam logic [COEF_W-1:0] COEF_UNITY    = COEF_W'(64'sd1 <<< COEF_FRAC_BITS);
    localparam logic [COEF_W-1:0] COEF_HALF     = COEF_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));
    localparam logic [COEF_W-1:0] COEF_NEG_HALF = COEF_W'(-(64'sd1 <<< (COEF_FRAC_BITS - 1)));
    localparam logic [COEF_W-1:0] COEF_TOP      = COEF_W'((64'sd1 <<< (COEF_W - 1)) - 64'sd1);
    localparam logic [COEF_W-1:0] COEF_BOTTOM   = COEF_W'(-(64'sd1 <<< (COEF_W - 1)));

    typedef enum int {
        MIX_MODEST,
        MIX_TOP,
        MIX_BOTTOM,
        MIX_RANDOM
    } coef_mix_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_ITEM,
        ROW_KNOWN
    } row_kind_t;

    // one output item: channel echo, both bands and the clip flag
    typedef struct packed {
        logic [CH_W-1:0]            ch;
        logic signed [SAMPLE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] hi;
        logic                       clip;
    } band_result_t;

    // directed stimulus: a register write, an item checked by the predictor,
    // or an item whose bands are typed in
    typedef struct packed {
        row_kind_t                  kind;
        logic [CFG_IDX_W-1:0]       idx;
        logic [COEF_W-1:0]          data;
        logic [CH_W-1:0]            ch;
        logic signed [SAMPLE_W-1:0] x;
        band_result_t               want;
    } stim_row_t;

    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index   = '0;
    logic [COEF_W-1:0]          cfg_data    = '0;
    logic                       in_valid    = 1'b0;
    logic                       in_ready;
    logic [CH_W-1:0]            channel     = '0;
    logic signed [SAMPLE_W-1:0] sample_in   = '0;
    logic                       out_valid;
    logic                       out_ready   = 1'b0;
    logic [CH_W-1:0]            channel_out;
    logic signed [SAMPLE_W-1:0] low_band;
    logic signed [SAMPLE_W-1:0] high_band;
    logic                       clipped;

    phase_matched_band_split_filter DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .channel     (channel),
        .sample_in   (sample_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .channel_out (channel_out),
        .low_band    (low_band),
        .high_band   (high_band),
        .clipped     (clipped)
    );

    always #CLK_HALF clk = ~clk;

    // predictor copy of the coefficients, sign extended
    longint fb_one_q    = 0;
    longint fb_two_q    = 0;
    longint lo_outer_q  = 0;
    longint lo_middle_q = 0;
    longint hi_outer_q  = 0;
    longint hi_middle_q = 0;

    // predictor copy of the per-channel history: inputs in q1.15, bands in q3.20
    longint x_prev  [CHANNELS];
    longint x_old   [CHANNELS];
    longint lo_prev [CHANNELS];
    longint lo_old  [CHANNELS];
    longint hi_prev [CHANNELS];
    longint hi_old  [CHANNELS];

    band_result_t expected_bands [$];
    stim_row_t    directed_rows  [$];
    band_result_t oldest_band;

    // pacing of both sides, changed per phase
    int idle_pct     = 0;
    int stall_pct    = 0;
    bit hold_request = 1'b0;
    bit offering     = 1'b0;
    bit cfg_pending  = 1'b0;

    int cycle_count     = 0;
    int fail_count      = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int clipped_seen    = 0;
    int reg_writes      = 0;
    int coef_settings   = 0;
    int holds_done      = 0;

    // round half up from the q.42 product sum to q3.20, saturate to the history width
    function automatic longint round_to_q20(input longint acc, inout bit sat);
        longint v;
        v = (acc + (64'sd1 <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
        if (v > longint'(HIST_MAX))
        begin
            sat = 1'b1;
            v = longint'(HIST_MAX);
        end
        else if (v < longint'(HIST_MIN))
        begin
            sat = 1'b1;
            v = longint'(HIST_MIN);
        end
        return v;
    endfunction

    // round half up from q3.20 to q1.15 and saturate
    function automatic longint round_to_q15(input longint v20, inout bit sat);
        longint v;
        v = (v20 + (64'sd1 <<< (X_SHIFT - 1))) >>> X_SHIFT;
        if (v > longint'(Q15_MAX))
        begin
            sat = 1'b1;
            v = longint'(Q15_MAX);
        end
        else if (v < longint'(Q15_MIN))
        begin
            sat = 1'b1;
            v = longint'(Q15_MIN);
        end
        return v;
    endfunction

    // both bands for one sample, then shift the channel's history;
    // a 4-bit channel never exceeds the channel count, so every item updates state
    function automatic band_result_t split_sample(input logic [CH_W-1:0] ch,
                                                  input logic signed [SAMPLE_W-1:0] x);
        band_result_t r;
        longint xw;
        longint x1w;
        longint x2w;
        longint lo_q20;
        longint hi_q20;
        bit sat;
        sat = 1'b0;
        xw  = longint'(x) <<< X_SHIFT;
        x1w = x_prev[ch] <<< X_SHIFT;
        x2w = x_old[ch] <<< X_SHIFT;
        // outer taps share a coefficient, feedback shares the denominator
        lo_q20 = round_to_q20(lo_outer_q * (xw + x2w) + lo_middle_q * x1w
                              - fb_one_q * lo_prev[ch] - fb_two_q * lo_old[ch], sat);
        hi_q20 = round_to_q20(hi_outer_q * (xw + x2w) + hi_middle_q * x1w
                              - fb_one_q * hi_prev[ch] - fb_two_q * hi_old[ch], sat);
        x_old[ch]   = x_prev[ch];
        x_prev[ch]  = longint'(x);
        lo_old[ch]  = lo_prev[ch];
        lo_prev[ch] = lo_q20;
        hi_old[ch]  = hi_prev[ch];
        hi_prev[ch] = hi_q20;
        r.ch   = ch;
        r.lo   = SAMPLE_W'(round_to_q15(lo_q20, sat));
        r.hi   = SAMPLE_W'(round_to_q15(hi_q20, sat));
        r.clip = sat;
        return r;
    endfunction

    // coefficient for one register under a given mix; modest sets keep the poles inside
    // the unit circle (|a1| < 0.95, 0 <= a2 < 0.9) so the output stays mostly in range
    function automatic logic [COEF_W-1:0] coef_for(input coef_mix_t mix,
                                                   input logic [CFG_IDX_W-1:0] idx);
        case (mix)
            MIX_TOP:    return COEF_TOP;
            MIX_BOTTOM: return COEF_BOTTOM;
            MIX_RANDOM: return COEF_W'($urandom);
            default:
            begin
                case (idx)
                    REG_FB_ONE: return COEF_W'(longint'($urandom_range(7969176)) - 3984588);
                    REG_FB_TWO: return COEF_W'($urandom_range(3774873));
                    default:    return COEF_W'(longint'($urandom_range(4194304)) - 2097152);
                endcase
            end
        endcase
    endfunction

    // one register write, visible to the block at the next rising edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
        longint v;
        v = longint'($signed(data));
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_data    <= data;
        cfg_pending = 1'b1;
        @(posedge clk);
        case (idx)
            REG_FB_ONE:      fb_one_q    = v;
            REG_FB_TWO:      fb_two_q    = v;
            REG_LOW_OUTER:   lo_outer_q  = v;
            REG_LOW_MIDDLE:  lo_middle_q = v;
            REG_HIGH_OUTER:  hi_outer_q  = v;
            REG_HIGH_MIDDLE: hi_middle_q = v;
            default:         ;
        endcase
        reg_writes++;
    endtask

    // offer one item, hold it until taken, then queue its expected bands
    task automatic send_item(input logic [CH_W-1:0] ch, input logic signed [SAMPLE_W-1:0] x,
                             input bit typed, input band_result_t typed_r);
        band_result_t r;
        if (cfg_pending)
        begin
            cfg_wr_en   <= 1'b0;
            cfg_pending = 1'b0;
        end
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        channel   <= ch;
        sample_in <= x;
        offering  = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = split_sample(ch, x);
        if (typed)
            r = typed_r;
        expected_bands.push_back(r);
        items_sent++;
    endtask

    // stop offering and wait until every queued band pair has come out
    task automatic drain_results();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
        while (expected_bands.size() != 0)
            @(posedge clk);
    endtask

    task automatic program_coefs(input coef_mix_t mix);
        drain_results();
        write_reg($urandom_range(1) ? REG_SPARE_LOW : REG_SPARE_HIGH, COEF_W'($urandom));
        for (int r = REG_FB_ONE; r <= REG_HIGH_MIDDLE; r++)
            write_reg(CFG_IDX_W'(r), coef_for(mix, CFG_IDX_W'(r)));
        coef_settings++;
    endtask

    task automatic run_phase(input coef_mix_t mix, input int idle, input int stall,
                             input bit pressure, input int count);
        logic [CH_W-1:0] ch;
        logic signed [SAMPLE_W-1:0] x;
        band_result_t no_band;
        program_coefs(mix);
        idle_pct  = idle;
        stall_pct = stall;
        ch = '0;
        no_band = '0;
        for (int k = 0; k < count; k++)
        begin
            if (pressure && (k % 75) == 0)
                hold_request = 1'b1;
            // a quarter of the items repeat the channel to hit the same-channel hold
            if ($urandom_range(3) != 0)
                ch = CH_W'($urandom_range(CHANNELS - 1));
            case ($urandom_range(15))
                0:       x = Q15_MAX;
                1:       x = Q15_MIN;
                2:       x = SAMPLE_W'($urandom_range(4)) - 16'sd2;
                default: x = SAMPLE_W'($urandom);
            endcase
            send_item(ch, x, 1'b0, no_band);
        end
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
        stim_row_t row;
        row      = '0;
        row.kind = ROW_CFG;
        row.idx  = idx;
        row.data = data;
        directed_rows.push_back(row);
    endtask

    task automatic add_item(input logic [CH_W-1:0] ch, input logic signed [SAMPLE_W-1:0] x);
        stim_row_t row;
        row      = '0;
        row.kind = ROW_ITEM;
        row.ch   = ch;
        row.x    = x;
        directed_rows.push_back(row);
    endtask

    task automatic add_known(input logic [CH_W-1:0] ch, input logic signed [SAMPLE_W-1:0] x,
                             input logic signed [SAMPLE_W-1:0] lo,
                             input logic signed [SAMPLE_W-1:0] hi, input logic clip);
        stim_row_t row;
        row           = '0;
        row.kind      = ROW_KNOWN;
        row.ch        = ch;
        row.x         = x;
        row.want.ch   = ch;
        row.want.lo   = lo;
        row.want.hi   = hi;
        row.want.clip = clip;
        directed_rows.push_back(row);
    endtask

    // receiver: random stalls per phase, plus a long counted hold-off on request
    // so the pipeline fills and in_ready drops while items keep being offered
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                for (int n = 0; n < HOLD_CYCLES; n++)
                begin
                    out_ready <= 1'b0;
                    @(posedge clk);
                end
                hold_request = 1'b0;
                holds_done++;
            end
            out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
        end
    end

    // output checker: every taken result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bands.size() == 0)
            begin
                $error("unexpected result: channel_out %0d low_band %0d high_band %0d",
                       channel_out, low_band, high_band);
                fail_count++;
            end
            else
            begin
                oldest_band = expected_bands.pop_front();
                if (channel_out !== oldest_band.ch)
                begin
                    $error("channel_out: expected %0d, got %0d", oldest_band.ch, channel_out);
                    fail_count++;
                end
                if (low_band !== oldest_band.lo)
                begin
                    $error("low_band: expected %0d, got %0d", oldest_band.lo, low_band);
                    fail_count++;
                end
                if (high_band !== oldest_band.hi)
                begin
                    $error("high_band: expected %0d, got %0d", oldest_band.hi, high_band);
                    fail_count++;
                end
                if (clipped !== oldest_band.clip)
                begin
                    $error("clipped: expected %0d, got %0d", oldest_band.clip, clipped);
                    fail_count++;
                end
                results_checked++;
                if (oldest_band.clip)
                    clipped_seen++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_phase_matched_band_split_filter NOT OK");
            $finish;
        end
    end

    initial
    begin
        stim_row_t row;

        for (int c = 0; c < CHANNELS; c++)
        begin
            x_prev[c]  = 0;
            x_old[c]   = 0;
            lo_prev[c] = 0;
            lo_old[c]  = 0;
            hi_prev[c] = 0;
            hi_old[c]  = 0;
        end

        // coefficients are zero after reset, so both bands are silent
        add_known(4'd0, Q15_MAX, 16'sd0, 16'sd0, 1'b0);
        add_known(4'd15, Q15_MIN, 16'sd0, 16'sd0, 1'b0);
        // unity outer tap on low, unity middle tap on high: low sees x + x2, high sees x1
        add_cfg(REG_LOW_OUTER, COEF_UNITY);
        add_cfg(REG_HIGH_MIDDLE, COEF_UNITY);
        add_known(4'd3, Q15_MAX, Q15_MAX, 16'sd0, 1'b0);
        add_known(4'd3, Q15_MIN, Q15_MIN, Q15_MAX, 1'b0);
        add_known(4'd3, 16'sd0, Q15_MAX, Q15_MIN, 1'b0);
        add_known(4'd3, 16'sd0, Q15_MIN, 16'sd0, 1'b0);
        // gain near four: full scale input clips at the q1.15 output
        add_cfg(REG_LOW_OUTER, COEF_TOP);
        add_cfg(REG_HIGH_MIDDLE, COEF_BOTTOM);
        add_known(4'd5, Q15_MAX, Q15_MAX, 16'sd0, 1'b1);
        add_known(4'd5, Q15_MIN, Q15_MIN, Q15_MIN, 1'b1);
        add_item(4'd1, 16'sd1);
        // runaway feedback drives the stored q3.20 history into saturation
        add_cfg(REG_FB_ONE, COEF_BOTTOM);
        add_cfg(REG_FB_TWO, COEF_TOP);
        add_cfg(REG_LOW_MIDDLE, COEF_TOP);
        add_cfg(REG_HIGH_OUTER, COEF_TOP);
        add_item(4'd5, Q15_MAX);
        add_item(4'd5, Q15_MAX);
        add_item(4'd5, Q15_MAX);
        add_item(4'd5, -16'sd1);
        add_item(4'd7, Q15_MIN);
        add_item(4'd7, Q15_MIN);
        add_item(4'd7, Q15_MIN);
        // writes past the register list change nothing
        add_cfg(REG_SPARE_LOW, '1);
        add_cfg(REG_SPARE_HIGH, '1);
        add_item(4'd5, Q15_MAX);
        // half gains: a half lsb at q1.15 rounds up on both signs
        add_cfg(REG_FB_ONE, COEF_ZERO);
        add_cfg(REG_FB_TWO, COEF_ZERO);
        add_cfg(REG_LOW_OUTER, COEF_HALF);
        add_cfg(REG_LOW_MIDDLE, COEF_ZERO);
        add_cfg(REG_HIGH_OUTER, COEF_NEG_HALF);
        add_cfg(REG_HIGH_MIDDLE, COEF_ZERO);
        add_known(4'd9, 16'sd1, 16'sd1, 16'sd0, 1'b0);
        add_known(4'd9, -16'sd1, 16'sd0, 16'sd1, 1'b0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part with light pacing on both sides
        idle_pct  = 17;
        stall_pct = 17;
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG)
            begin
                drain_results();
                write_reg(row.idx, row.data);
            end
            else
                send_item(row.ch, row.x, row.kind == ROW_KNOWN, row.want);
        end

        // random part: coefficient mix, sender idle %, receiver stall %, hold-offs, items
        run_phase(MIX_MODEST, 0, 0, 1'b0, 250);
        run_phase(MIX_TOP, 73, 0, 1'b0, 200);
        run_phase(MIX_RANDOM, 0, 73, 1'b0, 250);
        run_phase(MIX_MODEST, 17, 17, 1'b0, 250);
        run_phase(MIX_BOTTOM, 0, 0, 1'b1, 150);
        run_phase(MIX_RANDOM, 0, 0, 1'b0, 250);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("run covered %0d items over %0d coefficient sets (%0d register writes)",
                 items_sent, coef_settings, reg_writes);
        $display("%0d results checked, %0d with clipping, %0d long output hold-offs",
                 results_checked, clipped_seen, holds_done);
        if (fail_count == 0)
            $display("tb_phase_matched_band_split_filter OK");
        else
            $display("tb_phase_matched_band_split_filter NOT OK");
        $finish;
    end

endmodule
